// ===== rtl/annular_sector_hit_and_anchor_top_macros.svh =====
// Assertion macros for the annular sector hit and anchor block.
// Used by annular_sector_hit_and_anchor_top; expects clk_i and rst_ni in scope.
`ifndef ANNULAR_SECTOR_HIT_AND_ANCHOR_TOP_MACROS_SVH
`define ANNULAR_SECTOR_HIT_AND_ANCHOR_TOP_MACROS_SVH

// same-cycle implication
`define ASH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ash_pkg.sv =====
// Shared types and constants for the annular sector hit and anchor block.
// No dependencies.
package ash_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int N_STEPS      = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int LAT          = 8 + 2 * N_STEPS;

  localparam int VW = 33;  // cordic x/y width
  localparam int ZW = 29;  // angle accumulator width

  localparam logic [14:0] UNITS_TURN = 15'd23040;
  localparam logic signed [ZW-1:0] ANG_FULL    = 29'sd94371840;
  localparam logic signed [ZW-1:0] ANG_HALF    = 29'sd47185920;
  localparam logic signed [ZW-1:0] ANG_QUARTER = 29'sd23592960;
  localparam logic signed [ZW-1:0] ANG_3QUART  = 29'sd70778880;
  localparam logic [14:0] MIN_INNER2 = 15'd160;
  localparam logic signed [VW-1:0] INV_GAIN = 33'sd652032874;

  localparam logic [23:0] ARC_TAB [TAB_LEN] = '{
    24'd11796480, 24'd6963869, 24'd3679517, 24'd1867780, 24'd937515, 24'd469214,
    24'd234664, 24'd117339, 24'd58671, 24'd29335, 24'd14668, 24'd7334,
    24'd3667, 24'd1833, 24'd917, 24'd458, 24'd229, 24'd115,
    24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2
  };

  localparam logic [2:0] REG_BOX_LEFT   = 3'd0;
  localparam logic [2:0] REG_BOX_TOP    = 3'd1;
  localparam logic [2:0] REG_BOX_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BOX_HEIGHT = 3'd3;
  localparam logic [2:0] REG_RING_THICK = 3'd4;
  localparam logic [2:0] REG_START_ANG  = 3'd5;
  localparam logic [2:0] REG_SPAN_ANG   = 3'd6;

  typedef struct packed {
    logic               zero;
    logic               rad_ok;
    logic               hit;
    logic               whole;
    logic               flip;
    logic [14:0]        st;
    logic [14:0]        sp;
    logic signed [16:0] rc;
    logic signed [17:0] cx2;
    logic signed [17:0] cy2;
  } ctx_t;

endpackage

// ===== rtl/ash_if.sv =====
// Valid/ready channel interfaces for query points and results.
// No dependencies.
interface ash_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_x;
  logic [15:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink (input valid, point_x, point_y, output ready);
endinterface

interface ash_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] anchor_x;
  logic [15:0] anchor_y;
  modport source (output valid, hit, anchor_x, anchor_y, input ready);
  modport sink (input valid, hit, anchor_x, anchor_y, output ready);
endinterface

// ===== rtl/annular_sector_hit_and_anchor_top.sv =====
// Annular sector hit test and anchor point, fully pipelined.
// Depends on ash_pkg, ash_if.sv and annular_sector_hit_and_anchor_top_macros.svh.
//
// Usage:
//   pt_i carries one query point (point_x, point_y, Q12.4) per beat; res_o
//   returns one beat per point: hit plus the saturated anchor_x/anchor_y.
//   Beats come out in the order they went in.
//   Geometry and angle range are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while no point is in flight; writes take effect on the next clock.
// Timing:
//   The pipeline has three setup stages, one stage per vectoring CORDIC step,
//   three angle stages, one stage per rotation CORDIC step, a multiply stage
//   and the output register.
//   Throughput is one point per cycle while res_o is not stalled.
// Reset:
//   Clears all valid bits and loads the register defaults (empty box, 20 px
//   ring, sector from 0 to 90 degrees).
// Backpressure:
//   When res_o is stalled the whole pipeline freezes and pt_i.ready drops;
//   a bubble in the output register lets the pipeline keep advancing.
`include "annular_sector_hit_and_anchor_top_macros.svh"

module annular_sector_hit_and_anchor_top
  import ash_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  ash_in_if.sink      pt_i,
  ash_out_if.source   res_o
);

  logic signed [15:0] box_left_q, box_top_q;
  logic [14:0] box_width_q, box_height_q, ring_thick_q, start_ang_q, span_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q   <= '0;
      box_top_q    <= '0;
      box_width_q  <= '0;
      box_height_q <= '0;
      ring_thick_q <= 15'd320;
      start_ang_q  <= '0;
      span_ang_q   <= 15'd5760;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_LEFT:   box_left_q   <= cfg_data_i;
        REG_BOX_TOP:    box_top_q    <= cfg_data_i;
        REG_BOX_WIDTH:  box_width_q  <= cfg_data_i[14:0];
        REG_BOX_HEIGHT: box_height_q <= cfg_data_i[14:0];
        REG_RING_THICK: ring_thick_q <= cfg_data_i[14:0];
        REG_START_ANG:  start_ang_q  <= cfg_data_i[14:0];
        REG_SPAN_ANG:   span_ang_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [LAT-1:0] vld_q;
  logic           en, fire;

  assign en         = !vld_q[LAT-1] || res_o.ready;
  assign fire       = pt_i.valid && en;
  assign pt_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], fire};
    end
  end

  // stage A: offsets, box test, radii, angle range
  logic signed [15:0] px, py;
  logic signed [17:0] cx2_a, cy2_a;
  logic signed [16:0] lw_a, th_a;
  logic signed [18:0] dx_a, dy_a;
  logic signed [16:0] rin_a;
  logic [14:0] side_a, rinc_a;
  ctx_t ctx_a;
  logic box_a;

  logic signed [18:0] a_dx_q, a_dy_q;
  logic [14:0] a_side_q, a_rin_q;
  logic a_box_q;
  ctx_t a_ctx_q;

  always_comb begin
    px    = $signed(pt_i.point_x);
    py    = $signed(pt_i.point_y);
    cx2_a = $signed({box_left_q[15], box_left_q, 1'b0}) + $signed({3'b0, box_width_q});
    cy2_a = $signed({box_top_q[15], box_top_q, 1'b0}) + $signed({3'b0, box_height_q});
    dx_a  = $signed({px[15], px, 1'b0}) - $signed({cx2_a[17], cx2_a});
    dy_a  = $signed({py[15], py, 1'b0}) - $signed({cy2_a[17], cy2_a});
    lw_a  = $signed({box_left_q[15], box_left_q}) + $signed({2'b0, box_width_q});
    th_a  = $signed({box_top_q[15], box_top_q}) + $signed({2'b0, box_height_q});
    box_a = (box_width_q != '0) && (box_height_q != '0) &&
            (px >= box_left_q) && ($signed({px[15], px}) <= lw_a) &&
            (py >= box_top_q) && ($signed({py[15], py}) <= th_a);
    side_a = (box_width_q < box_height_q) ? box_width_q : box_height_q;
    rin_a  = $signed({2'b0, side_a}) - $signed({1'b0, ring_thick_q, 1'b0});
    rinc_a = (rin_a < $signed({2'b0, MIN_INNER2})) ? MIN_INNER2 : rin_a[14:0];
    ctx_a        = '0;
    ctx_a.cx2    = cx2_a;
    ctx_a.cy2    = cy2_a;
    ctx_a.rc     = $signed({2'b0, side_a}) - $signed({2'b0, ring_thick_q});
    ctx_a.st     = (start_ang_q >= UNITS_TURN) ? start_ang_q - UNITS_TURN : start_ang_q;
    ctx_a.whole  = span_ang_q >= UNITS_TURN;
    ctx_a.sp     = ctx_a.whole ? UNITS_TURN : span_ang_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q   <= dx_a;
      a_dy_q   <= dy_a;
      a_side_q <= side_a;
      a_rin_q  <= rinc_a;
      a_box_q  <= box_a;
      a_ctx_q  <= ctx_a;
    end
  end

  // stage B: squares, normalizing shift
  logic [17:0] adx_b, ady_b, m_b;
  logic [4:0]  p_b;
  ctx_t ctx_b;
  logic signed [37:0] b_dx2_q, b_dy2_q;
  logic [29:0] b_side2_q, b_rin2_q;
  logic [4:0]  b_sh_q;
  logic signed [18:0] b_dx_q, b_dy_q;
  logic b_box_q;
  ctx_t b_ctx_q;

  always_comb begin
    adx_b = a_dx_q[18] ? 18'(-a_dx_q) : a_dx_q[17:0];
    ady_b = a_dy_q[18] ? 18'(-a_dy_q) : a_dy_q[17:0];
    m_b   = (adx_b > ady_b) ? adx_b : ady_b;
    p_b   = '0;
    for (int k = 0; k < 18; k++) begin
      if (m_b[k]) p_b = 5'(k);
    end
    ctx_b      = a_ctx_q;
    ctx_b.zero = (a_dx_q == '0) && (a_dy_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_dx2_q   <= a_dx_q * a_dx_q;
      b_dy2_q   <= a_dy_q * a_dy_q;
      b_side2_q <= a_side_q * a_side_q;
      b_rin2_q  <= a_rin_q * a_rin_q;
      b_sh_q    <= 5'd28 - p_b;
      b_dx_q    <= a_dx_q;
      b_dy_q    <= a_dy_q;
      b_box_q   <= a_box_q;
      b_ctx_q   <= ctx_b;
    end
  end

  // stage C: radius test, scale and half-turn pre-rotation
  logic signed [VW-1:0] vx_q [N_STEPS+1];
  logic signed [VW-1:0] vy_q [N_STEPS+1];
  logic signed [ZW-1:0] vz_q [N_STEPS+1];
  ctx_t vctx_q [N_STEPS+1];

  logic [38:0] d2_c;
  logic signed [VW-1:0] xs_c, ys_c;
  ctx_t ctx_c;

  always_comb begin
    d2_c = {1'b0, b_dx2_q} + {1'b0, b_dy2_q};
    xs_c = $signed({{(VW-19){b_dx_q[18]}}, b_dx_q}) <<< b_sh_q;
    ys_c = $signed({{(VW-19){b_dy_q[18]}}, b_dy_q}) <<< b_sh_q;
    ctx_c        = b_ctx_q;
    ctx_c.rad_ok = b_box_q && (d2_c >= {9'b0, b_rin2_q}) && (d2_c <= {9'b0, b_side2_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q[0]   <= xs_c[VW-1] ? -xs_c : xs_c;
      vy_q[0]   <= xs_c[VW-1] ? -ys_c : ys_c;
      vz_q[0]   <= xs_c[VW-1] ? ANG_HALF : '0;
      vctx_q[0] <= ctx_c;
    end
  end

  // vectoring CORDIC, one step per stage
  for (genvar i = 0; i < N_STEPS; i++) begin : g_vec
    logic signed [ZW-1:0] arc;
    assign arc = $signed({{(ZW-24){1'b0}}, ARC_TAB[i]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!vy_q[i][VW-1]) begin
          vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] + arc;
        end else begin
          vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] - arc;
        end
        vctx_q[i+1] <= vctx_q[i];
      end
    end
  end

  // stage D: wrap angle, relative angle
  logic signed [ZW-1:0] ang_d, rel_d;
  logic signed [ZW-1:0] d_ang_q, d_rel_q;
  ctx_t d_ctx_q;

  always_comb begin
    ang_d = vz_q[N_STEPS];
    if (ang_d < 0) ang_d = ang_d + ANG_FULL;
    else if (ang_d >= ANG_FULL) ang_d = ang_d - ANG_FULL;
    rel_d = ang_d - $signed({2'b0, vctx_q[N_STEPS].st, 12'b0});
    if (rel_d < 0) rel_d = rel_d + ANG_FULL;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ang_q <= ang_d;
      d_rel_q <= rel_d;
      d_ctx_q <= vctx_q[N_STEPS];
    end
  end

  // stage E: sector test, clamp to nearer end
  logic signed [ZW-1:0] sp_e, st_e, tgt_e;
  logic in_sec_e;
  ctx_t ctx_e;
  logic signed [ZW-1:0] e_ang_q;
  ctx_t e_ctx_q;

  always_comb begin
    sp_e     = $signed({2'b0, d_ctx_q.sp, 12'b0});
    st_e     = $signed({2'b0, d_ctx_q.st, 12'b0});
    in_sec_e = !d_ctx_q.zero && (d_ctx_q.whole || d_rel_q <= sp_e);
    tgt_e    = d_ang_q;
    if (!in_sec_e) begin
      tgt_e = ((ANG_FULL - d_rel_q) <= (d_rel_q - sp_e)) ? st_e : st_e + sp_e;
    end
    if (tgt_e >= ANG_FULL) tgt_e = tgt_e - ANG_FULL;
    ctx_e     = d_ctx_q;
    ctx_e.hit = d_ctx_q.rad_ok && in_sec_e;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ang_q <= tgt_e;
      e_ctx_q <= ctx_e;
    end
  end

  // stage F: fold into the right half plane
  logic signed [VW-1:0] tx_q [N_STEPS+1];
  logic signed [VW-1:0] ty_q [N_STEPS+1];
  logic signed [ZW-1:0] tz_q [N_STEPS+1];
  ctx_t tctx_q [N_STEPS+1];
  logic signed [ZW-1:0] zf_f;
  logic flip_f;
  ctx_t ctx_f;

  always_comb begin
    zf_f   = e_ang_q;
    flip_f = 1'b0;
    if (e_ang_q > ANG_QUARTER && e_ang_q < ANG_3QUART) begin
      zf_f   = e_ang_q - ANG_HALF;
      flip_f = 1'b1;
    end else if (e_ang_q >= ANG_3QUART) begin
      zf_f = e_ang_q - ANG_FULL;
    end
    ctx_f      = e_ctx_q;
    ctx_f.flip = flip_f;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q[0]   <= INV_GAIN;
      ty_q[0]   <= '0;
      tz_q[0]   <= zf_f;
      tctx_q[0] <= ctx_f;
    end
  end

  // rotation CORDIC, one step per stage
  for (genvar i = 0; i < N_STEPS; i++) begin : g_rot
    logic signed [ZW-1:0] arc;
    assign arc = $signed({{(ZW-24){1'b0}}, ARC_TAB[i]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!tz_q[i][ZW-1]) begin
          tx_q[i+1] <= tx_q[i] - (ty_q[i] >>> i);
          ty_q[i+1] <= ty_q[i] + (tx_q[i] >>> i);
          tz_q[i+1] <= tz_q[i] - arc;
        end else begin
          tx_q[i+1] <= tx_q[i] + (ty_q[i] >>> i);
          ty_q[i+1] <= ty_q[i] - (tx_q[i] >>> i);
          tz_q[i+1] <= tz_q[i] + arc;
        end
        tctx_q[i+1] <= tctx_q[i];
      end
    end
  end

  // stage G: scale by mid radius
  logic signed [VW-1:0] c_g, s_g;
  logic signed [49:0] g_px_q, g_py_q;
  ctx_t g_ctx_q;

  always_comb begin
    c_g = tctx_q[N_STEPS].flip ? -tx_q[N_STEPS] : tx_q[N_STEPS];
    s_g = tctx_q[N_STEPS].flip ? -ty_q[N_STEPS] : ty_q[N_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_px_q  <= tctx_q[N_STEPS].rc * c_g;
      g_py_q  <= tctx_q[N_STEPS].rc * s_g;
      g_ctx_q <= tctx_q[N_STEPS];
    end
  end

  // stage H: add centre, round, saturate
  function automatic logic signed [21:0] anchor_of(logic signed [17:0] c2,
                                                   logic signed [49:0] prod);
    logic signed [52:0] sum;
    sum = $signed({{5{c2[17]}}, c2, 30'b0}) + $signed({{3{prod[49]}}, prod}) +
          $signed({23'b0, 1'b1, 29'b0} <<< 1);
    return sum[52:31];
  endfunction

  function automatic logic signed [21:0] centre_of(logic signed [17:0] c2);
    logic signed [18:0] t;
    t = $signed({c2[17], c2}) + 19'sd1;
    return $signed({{4{t[18]}}, t[18:1]});
  endfunction

  function automatic logic [15:0] sat16(logic signed [21:0] v);
    if (v > 22'sd32767) return 16'h7fff;
    if (v < -22'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  logic signed [21:0] ax_h, ay_h;
  logic h_hit_q;
  logic [15:0] h_ax_q, h_ay_q;

  always_comb begin
    if (g_ctx_q.zero) begin
      ax_h = centre_of(g_ctx_q.cx2);
      ay_h = centre_of(g_ctx_q.cy2);
    end else begin
      ax_h = anchor_of(g_ctx_q.cx2, g_px_q);
      ay_h = anchor_of(g_ctx_q.cy2, g_py_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_hit_q <= g_ctx_q.hit;
      h_ax_q  <= sat16(ax_h);
      h_ay_q  <= sat16(ay_h);
    end
  end

  assign res_o.valid    = vld_q[LAT-1];
  assign res_o.hit      = h_hit_q;
  assign res_o.anchor_x = h_ax_q;
  assign res_o.anchor_y = h_ay_q;

  `ASH_ASSERT_NXT(a_stall_hold, !en, $stable(vld_q), "valid bits moved during stall")
  `ASH_ASSERT_NOW(a_ang_wrap, vld_q[3+N_STEPS], (d_ang_q >= 0) && (d_ang_q < ANG_FULL),
    "vector angle out of range")
  `ASH_ASSERT_NOW(a_fold_range, vld_q[5+N_STEPS],
    (tz_q[0] >= -ANG_QUARTER) && (tz_q[0] <= ANG_QUARTER), "folded angle out of range")
  `ASH_ASSERT_NOW(a_centre_miss, vld_q[4+N_STEPS] && e_ctx_q.zero, !e_ctx_q.hit,
    "hit at centre point")

endmodule

// ===== verif/ash_checker.sv =====
// Checker for the annular sector hit and anchor block: watches both channels,
// predicts hit and anchor per point and compares. Depends on ash_pkg.
`timescale 1ns / 100ps

module ash_checker
  import ash_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        pt_valid_i,
  input  logic        pt_ready_i,
  input  logic [15:0] pt_x_i,
  input  logic [15:0] pt_y_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic        res_hit_i,
  input  logic [15:0] res_ax_i,
  input  logic [15:0] res_ay_i,
  output int          errors_o,
  output int          pending_o,
  output int          hits_o
);

  typedef struct packed {
    logic        hit;
    logic [15:0] ax;
    logic [15:0] ay;
  } anchor_res_t;

  anchor_res_t expected_q[$];
  logic [15:0] geo_left, geo_top;
  logic [14:0] geo_w, geo_h, geo_thick, geo_start, geo_span;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint point_angle(longint x, longint y);
    longint ax, ay, m, z, nx;
    int s;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m = ax > ay ? ax : ay;
    z = 0;
    s = 0;
    while (s < 40 && (m << s) < (64'sd1 << 28)) s++;
    x = x << s;
    y = y << s;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = ANG_HALF;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += ARC_TAB[i];
      end else begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= ARC_TAB[i];
      end
      x = nx;
    end
    if (z < 0) z += ANG_FULL;
    if (z >= ANG_FULL) z -= ANG_FULL;
    return z;
  endfunction

  function automatic void cos_sin(longint a, output longint c, output longint s);
    longint x, y, nx, z;
    bit flip;
    x = INV_GAIN;
    y = 0;
    z = a;
    flip = 0;
    if (z > ANG_QUARTER && z < ANG_3QUART) begin
      z -= ANG_HALF;
      flip = 1;
    end else if (z >= ANG_3QUART) begin
      z -= ANG_FULL;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= ARC_TAB[i];
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += ARC_TAB[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic anchor_res_t predict_anchor(logic [15:0] px16, logic [15:0] py16);
    anchor_res_t r;
    longint px, py, l, t, w, h, th, cx2, cy2, dx, dy, side, rin, st, sp;
    longint ang, rel, c, s, ax, ay, rc, d2, rin_min;
    bit whole, in_sec;
    px = longint'(signed'(px16));
    py = longint'(signed'(py16));
    l = longint'(signed'(geo_left));
    t = longint'(signed'(geo_top));
    w = geo_w;
    h = geo_h;
    th = geo_thick;
    rin_min = longint'(MIN_INNER2);
    cx2 = 2 * l + w;
    cy2 = 2 * t + h;
    dx = 2 * px - cx2;
    dy = 2 * py - cy2;
    side = w < h ? w : h;
    rin = side - 2 * th;
    st = longint'(geo_start % UNITS_TURN) * 4096;
    whole = geo_span >= UNITS_TURN;
    sp = (whole ? longint'(UNITS_TURN) : longint'(geo_span)) * 4096;
    rel = 0;
    ang = 0;
    in_sec = 0;
    r.hit = 0;
    if (rin < rin_min) rin = rin_min;
    if (dx != 0 || dy != 0) begin
      ang = point_angle(dx, dy);
      rel = ang - st;
      if (rel < 0) rel += ANG_FULL;
      in_sec = whole || rel <= sp;
    end
    if (w > 0 && h > 0 && px >= l && px <= l + w && py >= t && py <= t + h) begin
      d2 = dx * dx + dy * dy;
      if (d2 >= rin * rin && d2 <= side * side && in_sec) r.hit = 1;
    end
    if (dx == 0 && dy == 0) begin
      ax = floor_shr(cx2 + 1, 1);
      ay = floor_shr(cy2 + 1, 1);
    end else begin
      rc = side - th;
      if (!in_sec) ang = ((ANG_FULL - rel) <= (rel - sp)) ? st : st + sp;
      if (ang >= ANG_FULL) ang -= ANG_FULL;
      cos_sin(ang, c, s);
      ax = floor_shr(cx2 * (64'sd1 << 30) + rc * c + (64'sd1 << 30), 31);
      ay = floor_shr(cy2 * (64'sd1 << 30) + rc * s + (64'sd1 << 30), 31);
    end
    r.ax = clamp16(ax);
    r.ay = clamp16(ay);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors_o++;
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    anchor_res_t e;
    if (!rst_ni) begin
      geo_left <= '0;
      geo_top <= '0;
      geo_w <= '0;
      geo_h <= '0;
      geo_thick <= 15'd320;
      geo_start <= '0;
      geo_span <= 15'd5760;
      expected_q.delete();
      errors_o <= 0;
      hits_o <= 0;
    end else begin
      if (pt_valid_i && pt_ready_i) expected_q.push_back(predict_anchor(pt_x_i, pt_y_i));
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result beat", $time);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          if (res_hit_i) hits_o++;
          if (res_hit_i !== e.hit) report_mismatch("hit", 16'(res_hit_i), 16'(e.hit));
          if (res_ax_i !== e.ax) report_mismatch("anchor_x", res_ax_i, e.ax);
          if (res_ay_i !== e.ay) report_mismatch("anchor_y", res_ay_i, e.ay);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BOX_LEFT: geo_left <= cfg_data_i;
          REG_BOX_TOP: geo_top <= cfg_data_i;
          REG_BOX_WIDTH: geo_w <= cfg_data_i[14:0];
          REG_BOX_HEIGHT: geo_h <= cfg_data_i[14:0];
          REG_RING_THICK: geo_thick <= cfg_data_i[14:0];
          REG_START_ANG: geo_start <= cfg_data_i[14:0];
          REG_SPAN_ANG: geo_span <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for annular_sector_hit_and_anchor_top: drives points and
// register settings, ash_checker predicts and compares. Depends on ash_pkg, ash_if.sv.
`timescale 1ns / 100ps

module tb
  import ash_pkg::*;
;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          errors, pending, hits, sent, idle_cycles;
  int          src_idle_pct, snk_idle_pct;

  ash_in_if  pt();
  ash_out_if res();

  annular_sector_hit_and_anchor_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .pt_i(pt), .res_o(res)
  );

  ash_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pt_valid_i(pt.valid), .pt_ready_i(pt.ready), .pt_x_i(pt.point_x),
    .pt_y_i(pt.point_y), .res_valid_i(res.valid), .res_ready_i(res.ready),
    .res_hit_i(res.hit), .res_ax_i(res.anchor_x), .res_ay_i(res.anchor_y),
    .errors_o(errors), .pending_o(pending), .hits_o(hits)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pt.valid && pt.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays up after a beat until the next point or an idle cycle replaces it
  task automatic send_point(logic [15:0] x, logic [15:0] y);
    while ($urandom_range(99) < src_idle_pct) begin
      pt.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt.valid <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    do @(posedge clk_i); while (!pt.ready);
    sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic drain();
    pt.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic set_geometry(logic [15:0] l, logic [15:0] t, logic [14:0] w,
                              logic [14:0] h, logic [14:0] th, logic [14:0] st,
                              logic [14:0] sp);
    drain();
    write_reg(REG_BOX_LEFT, l);
    write_reg(REG_BOX_TOP, t);
    write_reg(REG_BOX_WIDTH, {1'b0, w});
    write_reg(REG_BOX_HEIGHT, {1'b0, h});
    write_reg(REG_RING_THICK, {1'b0, th});
    write_reg(REG_START_ANG, {1'b0, st});
    write_reg(REG_SPAN_ANG, {1'b0, sp});
    cfg_we_i <= 1'b0;
  endtask

  // mostly points near the ring, some anywhere
  task automatic random_points(int n, int l, int t, int w, int h);
    int cx, cy, r, dx, dy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_point(16'($urandom), 16'($urandom));
      end else begin
        cx = l + w / 2;
        cy = t + h / 2;
        r = (w < h ? w : h) / 2 + 40;
        dx = $urandom_range(2 * r) - r;
        dy = $urandom_range(2 * r) - r;
        send_point(16'(cx + dx), 16'(cy + dy));
      end
    end
  endtask

  task automatic random_phase(int n);
    int l, t, w, h;
    w = $urandom_range(15) == 0 ? $urandom_range(32767) : $urandom_range(4000);
    h = $urandom_range(7) == 0 ? w : $urandom_range(4000);
    l = $urandom_range(8000) - 4000;
    t = $urandom_range(8000) - 4000;
    set_geometry(16'(l), 16'(t), 15'(w), 15'(h),
                 15'($urandom_range(3) == 0 ? $urandom : $urandom_range(800)),
                 15'($urandom_range(3) == 0 ? $urandom : $urandom_range(23039)),
                 15'($urandom_range(5) == 0 ? $urandom : $urandom_range(23040)));
    random_points(n, l, t, w, h);
  endtask

  initial begin
    sent = 0;
    src_idle_pct = 27;
    snk_idle_pct = 76;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: empty box
    send_point(16'h0000, 16'h0000);
    send_point(16'h7fff, 16'h8000);
    set_geometry(16'h0000, 16'h0000, 15'd1600, 15'd1600, 15'd320, 15'd0, 15'd5760);
    send_point(16'd800, 16'd800);        // centre
    send_point(16'd1600, 16'd800);       // on outer edge, 0 deg
    send_point(16'd1100, 16'd1300);      // in sector
    send_point(16'd200, 16'd200);        // outside angle
    send_point(16'd0, 16'd1600);         // box corner
    send_point(16'd1601, 16'd800);       // just outside box
    send_point(16'h8000, 16'h7fff);
    send_point(16'h7fff, 16'h7fff);
    // start angle beyond a turn, wrapped back into range
    set_geometry(16'hff00, 16'hff00, 15'd640, 15'd960, 15'd64, 15'd32000, 15'd9000);
    send_point(16'd10, 16'd64);
    send_point(16'hfe00, 16'd64);
    send_point(16'd64, 16'hff00);
    send_point(16'd64, 16'd200);
    // full turn, thick ring, inner radius clamped to its minimum
    set_geometry(16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
    send_point(16'h8000, 16'h8000);
    send_point(16'hbfff, 16'hbfff);
    send_point(16'h7fff, 16'h7fff);
    set_geometry(16'h7fff, 16'h7fff, 15'd100, 15'd100, 15'd0, 15'd23039, 15'd23040);
    send_point(16'h7fff, 16'h7fff);
    send_point(16'h7fff + 16'd50, 16'h7fff);
    set_geometry(16'd0, 16'd0, 15'd0, 15'd800, 15'd10, 15'd0, 15'd0);
    send_point(16'd0, 16'd400);
    send_point(16'd0, 16'd0);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = ph == 0 ? 27 : (ph == 1 ? 76 : 0);
      snk_idle_pct = ph == 0 ? 76 : (ph == 1 ? 27 : 0);
      for (int k = 0; k < 6; k++) random_phase(30);
    end
    drain();
    $display("%0d points checked over many box, ring and sector settings, %0d hits",
             sent, hits);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
